FILE: design/fbpa_pkg.sv
// Shared widths, request codes, status codes, config register indices and reset values for the block pool allocator.
package fbpa_pkg;

    localparam int ADDR_W      = 32;
    localparam int BYTES_W     = 17;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 2'd2;

    localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 17'd4;
    localparam logic [COUNT_W-1:0] RESET_BLOCKS    = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_SAT       = 9'd511;

endpackage

FILE: design/fbpa_stack.sv
// Freed-address stack storage: one write port, one registered read port.
module fbpa_stack #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [fbpa_pkg::ADDR_W-1:0] rd_data
);

    logic [fbpa_pkg::ADDR_W-1:0] mem [DEPTH];
    logic [fbpa_pkg::ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator.
// Response: a free or a never-used-block allocate answers in the cycle after accept;
// an allocate served from the freed stack answers after the stack RAM read and the ST_POP state.
// Throughput: one request per cycle while out_ready is high; no request is taken in ST_POP.
// Reset: pool restarts with base 0, 4-byte blocks, 256 blocks; a config write to base, size or count restarts it.
// The stack RAM is not cleared; only pushed entries are ever read.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]         block_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]         granted_address,
    output logic [fbpa_pkg::STATUS_W-1:0]       status,
    output logic [fbpa_pkg::COUNT_W-1:0]        free_count
);

    localparam int DW   = $clog2(MAX_BLOCKS + 1);
    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int FT_W = $clog2(512 + MAX_BLOCKS);

    typedef enum logic {ST_IDLE, ST_POP} state_t;

    state_t                         state_reg;
    logic                           out_valid_reg;
    logic [fbpa_pkg::ADDR_W-1:0]    granted_reg;
    logic [fbpa_pkg::STATUS_W-1:0]  status_reg;
    logic [fbpa_pkg::COUNT_W-1:0]   free_count_reg;

    logic [fbpa_pkg::ADDR_W-1:0]    base_reg;
    logic [fbpa_pkg::BYTES_W-1:0]   bytes_reg;
    logic [fbpa_pkg::COUNT_W-1:0]   blocks_reg;

    logic [fbpa_pkg::COUNT_W-1:0]   fresh_index_reg;
    logic [fbpa_pkg::ADDR_W-1:0]    fresh_addr_reg;
    logic [DW-1:0]                  depth_reg;
    logic [FT_W-1:0]                total_reg;

    logic                           in_fire;
    logic                           stack_full;
    logic                           stack_empty;
    logic [fbpa_pkg::COUNT_W-1:0]   eff_blocks;
    logic [fbpa_pkg::BYTES_W-1:0]   eff_bytes;
    logic [DW-1:0]                  depth_dec;
    logic                           wr_en;
    logic                           rd_en;
    logic [fbpa_pkg::ADDR_W-1:0]    rd_data;

    function automatic logic [fbpa_pkg::COUNT_W-1:0] clamp_blocks(
        input logic [fbpa_pkg::COUNT_W-1:0] v
    );
        logic [fbpa_pkg::COUNT_W-1:0] r;
        if (32'(v) > 32'(MAX_BLOCKS))
        begin
            r = fbpa_pkg::COUNT_W'(MAX_BLOCKS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [fbpa_pkg::COUNT_W-1:0] sat_count(input logic [FT_W-1:0] v);
        logic [fbpa_pkg::COUNT_W-1:0] r;
        if (v > FT_W'(fbpa_pkg::COUNT_SAT))
        begin
            r = fbpa_pkg::COUNT_SAT;
        end
        else
        begin
            r = v[fbpa_pkg::COUNT_W-1:0];
        end
        return r;
    endfunction

    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire     = in_valid && in_ready;
    assign stack_full  = (depth_reg == DW'(MAX_BLOCKS));
    assign stack_empty = (depth_reg == '0);
    assign depth_dec   = depth_reg - DW'(1);
    assign eff_blocks  = clamp_blocks(blocks_reg);
    assign eff_bytes   = (bytes_reg < fbpa_pkg::MIN_BLOCK_BYTES) ?
                         fbpa_pkg::MIN_BLOCK_BYTES : bytes_reg;

    assign wr_en = in_fire && (cmd == fbpa_pkg::CMD_FREE) && !stack_full;
    assign rd_en = in_fire && (cmd == fbpa_pkg::CMD_ALLOC) && !stack_empty;

    fbpa_stack #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (block_address),
        .rd_en   (rd_en),
        .rd_addr (depth_dec[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            granted_reg     <= '0;
            status_reg      <= fbpa_pkg::STATUS_OK;
            free_count_reg  <= '0;
            base_reg        <= '0;
            bytes_reg       <= fbpa_pkg::MIN_BLOCK_BYTES;
            blocks_reg      <= fbpa_pkg::RESET_BLOCKS;
            fresh_index_reg <= '0;
            fresh_addr_reg  <= '0;
            depth_reg       <= '0;
            total_reg       <= FT_W'(clamp_blocks(fbpa_pkg::RESET_BLOCKS));
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    fbpa_pkg::REG_BASE_ADDRESS:
                    begin
                        base_reg        <= cfg_data;
                        fresh_index_reg <= '0;
                        fresh_addr_reg  <= cfg_data;
                        depth_reg       <= '0;
                        total_reg       <= FT_W'(eff_blocks);
                    end
                    fbpa_pkg::REG_BLOCK_BYTES:
                    begin
                        bytes_reg       <= cfg_data[fbpa_pkg::BYTES_W-1:0];
                        fresh_index_reg <= '0;
                        fresh_addr_reg  <= base_reg;
                        depth_reg       <= '0;
                        total_reg       <= FT_W'(eff_blocks);
                    end
                    fbpa_pkg::REG_BLOCKS_IN_USE:
                    begin
                        blocks_reg      <= cfg_data[fbpa_pkg::COUNT_W-1:0];
                        fresh_index_reg <= '0;
                        fresh_addr_reg  <= base_reg;
                        depth_reg       <= '0;
                        total_reg       <= FT_W'(clamp_blocks(
                                               cfg_data[fbpa_pkg::COUNT_W-1:0]));
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (cmd == fbpa_pkg::CMD_FREE)
                        begin
                            out_valid_reg <= 1'b1;
                            granted_reg   <= '0;
                            if (stack_full)
                            begin
                                status_reg     <= fbpa_pkg::STATUS_FULL;
                                free_count_reg <= sat_count(total_reg);
                            end
                            else
                            begin
                                status_reg     <= fbpa_pkg::STATUS_OK;
                                free_count_reg <= sat_count(total_reg + FT_W'(1));
                                depth_reg      <= depth_reg + DW'(1);
                                total_reg      <= total_reg + FT_W'(1);
                            end
                        end
                        else if (!stack_empty)
                        begin
                            // result follows once the stack RAM read returns
                            depth_reg <= depth_dec;
                            total_reg <= total_reg - FT_W'(1);
                            state_reg <= ST_POP;
                        end
                        else if (fresh_index_reg < eff_blocks)
                        begin
                            out_valid_reg   <= 1'b1;
                            granted_reg     <= fresh_addr_reg;
                            status_reg      <= fbpa_pkg::STATUS_OK;
                            free_count_reg  <= sat_count(total_reg - FT_W'(1));
                            fresh_index_reg <= fresh_index_reg + fbpa_pkg::COUNT_W'(1);
                            fresh_addr_reg  <= fresh_addr_reg + fbpa_pkg::ADDR_W'(eff_bytes);
                            total_reg       <= total_reg - FT_W'(1);
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            granted_reg    <= '0;
                            status_reg     <= fbpa_pkg::STATUS_EMPTY;
                            free_count_reg <= sat_count(total_reg);
                        end
                    end
                end
                ST_POP:
                begin
                    out_valid_reg  <= 1'b1;
                    granted_reg    <= rd_data;
                    status_reg     <= fbpa_pkg::STATUS_OK;
                    free_count_reg <= sat_count(total_reg);
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign free_count      = free_count_reg;

endmodule
